// File: rtl/vnm_pkg.sv
package vnm_pkg;

    localparam int OUT_ID_W  = 32;
    localparam int ACT_W     = 3;
    localparam int NOTE_W    = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [ACT_W-1:0] ACT_NOTE_ON    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NOTE_OFF   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEDAL_DOWN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PEDAL_UP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_VRD,
        ST_FIN,
        ST_PSCAN,
        ST_PEMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_issue;
        logic pscan_step;
        logic pemit_commit;
        logic fin_commit;
        logic use_pidx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_addr;
        logic held_none;
        logic pslot_hit;
        logic last_held;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/vnm_if.sv
interface vnm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [6:0] note;
    logic       force_req;

    modport source (output valid, output action, output note, output force_req, input ready);
    modport sink (input valid, input action, input note, input force_req, output ready);
endinterface

interface vnm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] on_id;
    logic [31:0] off_id;
    logic [6:0]  active_count;
    logic        full_flag;
    logic        last;

    modport source (
        output valid, output on_id, output off_id, output active_count,
        output full_flag, output last, input ready
    );
    modport sink (
        input valid, input on_id, input off_id, input active_count,
        input full_flag, input last, output ready
    );
endinterface

// File: rtl/voice_note_mapper_with_sustain.sv
// note on / off: the result word follows a scan of the note store, one slot a cycle, then a
// voice id fetch and the commit; the next item is taken once that word is committed
// pedal down, clear all, spare codes, idle pedal up: no scan, straight to the result word commit
// pedal up with held voices: a slot sweep commits one release word per held voice
// one item in flight; a stalled result word holds off the next commit until it is taken
// reset (i_rst_n low, synchronous): empty table, pedal up, id counter at one, no pending word
module voice_note_mapper_with_sustain import vnm_pkg::*; #(
    parameter int VOICES  = 64,
    parameter int ID_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vnm_in_if.sink    i_in,
    vnm_out_if.source o_out
);

    // command and status between the sequencer and the slot datapath
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    // sequencer: idle, note scan, voice fetch, commit, or held-voice sweep
    vnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath: slot valid and held flags, note and voice id stores, counters,
    // and the output word register that parts the input side from the output side
    vnm_dp #(
        .VOICES  (VOICES),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_in.action),
        .i_note         (i_in.note),
        .i_force_req    (i_in.force_req),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_on_id        (o_out.on_id),
        .o_off_id       (o_out.off_id),
        .o_active_count (o_out.active_count),
        .o_full_flag    (o_out.full_flag),
        .o_last         (o_out.last)
    );

endmodule

// File: rtl/vnm_ram.sv
module vnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/vnm_ctrl.sv
module vnm_ctrl import vnm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  t_sts             i_sts,
    output logic             o_in_ready,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_action) inside
                        ACT_NOTE_ON, ACT_NOTE_OFF: n_state = ST_SCAN;
                        ACT_PEDAL_UP:              n_state = i_sts.held_none ? ST_FIN : ST_PSCAN;
                        default:                   n_state = ST_FIN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.last_addr) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: n_state = ST_VRD;
            ST_VRD:      n_state = ST_FIN;
            ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PSCAN: begin
                if (i_sts.pslot_hit) begin
                    n_state = ST_PEMIT;
                end
            end
            ST_PEMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_held ? ST_IDLE : ST_PSCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = accept;
            end
            ST_SCAN:     o_cmd.scan_issue = 1'b1;
            ST_SCAN_END: ;
            ST_VRD:      ;
            ST_FIN:      o_cmd.fin_commit = i_sts.out_free;
            ST_PSCAN: begin
                o_cmd.use_pidx   = 1'b1;
                o_cmd.pscan_step = !i_sts.pslot_hit;
            end
            ST_PEMIT: begin
                o_cmd.use_pidx     = 1'b1;
                o_cmd.pemit_commit = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/vnm_dp.sv
module vnm_dp import vnm_pkg::*; #(
    parameter int VOICES  = 64,
    parameter int ID_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [NOTE_W-1:0]    i_note,
    input  logic                 i_force_req,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [OUT_ID_W-1:0]  o_on_id,
    output logic [OUT_ID_W-1:0]  o_off_id,
    output logic [CNT_OUT_W-1:0] o_active_count,
    output logic                 o_full_flag,
    output logic                 o_last
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    logic [VOICES-1:0]   r_valid;
    logic [VOICES-1:0]   r_held;
    logic                r_pedal;
    logic [ID_BITS-1:0]  r_next;
    logic [CW-1:0]       r_total;
    logic [CW-1:0]       r_held_cnt;

    logic [ACT_W-1:0]    r_action;
    logic [NOTE_W-1:0]   r_note;
    logic                r_force;
    logic [IW-1:0]       r_rd_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_match_found;
    logic [IW-1:0]       r_match_idx;
    logic                r_free_found;
    logic [IW-1:0]       r_free_idx;

    logic                r_out_valid;
    logic [OUT_ID_W-1:0] r_on_id;
    logic [OUT_ID_W-1:0] r_off_id;
    logic [CW-1:0]       r_count;
    logic                r_full;
    logic                r_last;

    logic [NOTE_W-1:0]   note_rdata;
    logic [ID_BITS-1:0]  voice_rdata;
    logic [IW-1:0]       voice_raddr;
    logic                out_free;
    logic                off_release;
    logic                slot_ok;
    logic [IW-1:0]       slot;
    logic [ID_BITS-1:0]  n_next;
    logic [CW-1:0]       n_total;
    logic [ID_BITS-1:0]  n_off;
    logic                ram_we;

    assign out_free    = !r_out_valid || i_out_ready;
    assign off_release = r_match_found && (!r_pedal || r_force);
    assign slot_ok     = r_free_found || r_match_found;
    assign slot        = (r_free_found && (!r_match_found || (r_free_idx < r_match_idx)))
                         ? r_free_idx : r_match_idx;
    assign voice_raddr = i_cmd.use_pidx ? r_rd_idx : r_match_idx;
    assign ram_we      = i_cmd.fin_commit && (r_action == ACT_NOTE_ON) && slot_ok;

    // id counter steps past zero on wrap
    always_comb begin
        n_next = r_next + ID_BITS'(1);
        if (n_next == '0) begin
            n_next = ID_BITS'(1);
        end
    end

    always_comb begin
        n_total = r_total;
        n_off   = '0;
        case (r_action)
            ACT_NOTE_ON: begin
                n_total = r_total - CW'(r_match_found) + CW'(slot_ok);
                n_off   = r_match_found ? voice_rdata : '0;
            end
            ACT_NOTE_OFF: begin
                n_total = r_total - CW'(off_release);
                n_off   = off_release ? voice_rdata : '0;
            end
            ACT_CLEAR_ALL: n_total = '0;
            default: ;
        endcase
    end

    vnm_ram #(.WIDTH(NOTE_W), .DEPTH(VOICES)) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_note),
        .i_raddr (r_rd_idx),
        .o_rdata (note_rdata)
    );

    vnm_ram #(.WIDTH(ID_BITS), .DEPTH(VOICES)) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_next),
        .i_raddr (voice_raddr),
        .o_rdata (voice_rdata)
    );

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx      <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_action      <= ACT_CLEAR_ALL;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.start) begin
                r_rd_idx      <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
                r_action      <= i_action;
            end else if (i_cmd.scan_issue || i_cmd.pscan_step || i_cmd.pemit_commit) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            if (r_cmp_vld) begin
                if (!r_valid[r_cmp_idx]) begin
                    if (!r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end else if ((note_rdata == r_note) && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (i_cmd.start) begin
            r_note  <= i_note;
            r_force <= i_force_req;
        end
        if (r_cmp_vld) begin
            if (!r_valid[r_cmp_idx]) begin
                if (!r_free_found) begin
                    r_free_idx <= r_cmp_idx;
                end
            end else if ((note_rdata == r_note) && !r_match_found) begin
                r_match_idx <= r_cmp_idx;
            end
        end
    end

    // slot table state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_held      <= '0;
            r_pedal     <= 1'b0;
            r_next      <= ID_BITS'(1);
            r_total     <= '0;
            r_held_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.start && (i_action == ACT_PEDAL_UP)) begin
                r_pedal <= 1'b0;
            end
            if (i_cmd.pemit_commit) begin
                r_out_valid        <= 1'b1;
                r_valid[r_rd_idx]  <= 1'b0;
                r_held[r_rd_idx]   <= 1'b0;
                r_total            <= r_total - CW'(1);
                r_held_cnt         <= r_held_cnt - CW'(1);
            end
            if (i_cmd.fin_commit) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
                case (r_action)
                    ACT_NOTE_ON: begin
                        if (r_match_found) begin
                            r_valid[r_match_idx] <= 1'b0;
                            r_held[r_match_idx]  <= 1'b0;
                            r_held_cnt <= r_held_cnt - CW'(r_held[r_match_idx]);
                        end
                        if (slot_ok) begin
                            r_valid[slot] <= 1'b1;
                            r_held[slot]  <= 1'b0;
                            r_next        <= n_next;
                        end
                    end
                    ACT_NOTE_OFF: begin
                        if (off_release) begin
                            r_valid[r_match_idx] <= 1'b0;
                            r_held[r_match_idx]  <= 1'b0;
                            r_held_cnt <= r_held_cnt - CW'(r_held[r_match_idx]);
                        end else if (r_match_found && !r_held[r_match_idx]) begin
                            r_held[r_match_idx] <= 1'b1;
                            r_held_cnt          <= r_held_cnt + CW'(1);
                        end
                    end
                    ACT_PEDAL_DOWN: r_pedal <= 1'b1;
                    ACT_PEDAL_UP:   r_pedal <= 1'b0;
                    ACT_CLEAR_ALL: begin
                        r_valid    <= '0;
                        r_held     <= '0;
                        r_pedal    <= 1'b0;
                        r_held_cnt <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.pemit_commit) begin
            r_on_id  <= '0;
            r_off_id <= OUT_ID_W'(voice_rdata);
            r_count  <= r_total - CW'(1);
            r_full   <= 1'b0;
            r_last   <= (r_held_cnt == CW'(1));
        end else if (i_cmd.fin_commit) begin
            r_on_id  <= ((r_action == ACT_NOTE_ON) && slot_ok) ? OUT_ID_W'(r_next) : '0;
            r_off_id <= OUT_ID_W'(n_off);
            r_count  <= n_total;
            r_full   <= (r_action == ACT_NOTE_ON) && !slot_ok;
            r_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_on_id        = r_on_id;
    assign o_off_id       = r_off_id;
    assign o_active_count = CNT_OUT_W'(r_count);
    assign o_full_flag    = r_full;
    assign o_last         = r_last;

    assign o_sts.last_addr = (r_rd_idx == IW'(VOICES - 1));
    assign o_sts.held_none = (r_held_cnt == '0);
    assign o_sts.pslot_hit = r_valid[r_rd_idx] && r_held[r_rd_idx];
    assign o_sts.last_held = (r_held_cnt == CW'(1));
    assign o_sts.out_free  = out_free;

endmodule
